### sv/lobm_pkg.sv
`timescale 1ns / 1ps
package lobm_pkg;
  localparam int unsigned BOOK_SLOTS_DEF = 32;

  localparam logic [2:0] KIND_TRADE     = 3'd0;
  localparam logic [2:0] KIND_RESTED    = 3'd1;
  localparam logic [2:0] KIND_DONE      = 3'd2;
  localparam logic [2:0] KIND_FOK_REJ   = 3'd3;
  localparam logic [2:0] KIND_CANCELLED = 3'd4;
  localparam logic [2:0] KIND_NOT_FOUND = 3'd5;
  localparam logic [2:0] KIND_FULL      = 3'd6;

  localparam logic [1:0] TYPE_LIMIT  = 2'd0;
  localparam logic [1:0] TYPE_MARKET = 2'd1;
  localparam logic [1:0] TYPE_FOK    = 2'd2;
  // The unused code trades and rests like a limit order.
  localparam logic [1:0] TYPE_LIMIT3 = 2'd3;

  localparam logic FUNC_ADD    = 1'b0;
  localparam logic FUNC_CANCEL = 1'b1;

  typedef struct packed {
    logic [31:0] id;
    logic [31:0] price;
    logic [31:0] qty;
    logic        valid;
  } entry_t;

  // Book command broadcast to every cell of one chain.
  typedef struct packed {
    logic        ins;      // insert the carried entry in sorted order
    logic        rm;       // remove cells whose kill flag is set
    logic        dec;      // lower the head quantity
    logic        is_bid;
    logic [31:0] key;      // id searched for
    logic [31:0] amount;   // amount taken from head
    entry_t      new_entry;
  } book_cmd_t;
endpackage

### sv/limit_order_book_matcher_unit.sv
`timescale 1ns / 1ps
// Price-time limit order book with two sorted cell chains (bids best-high,
// asks best-low). An add passes through the match, rest and status states and
// a final out state before the next input is accepted; matching drains the
// head cell of the opposite chain at one trade per cycle while the output is
// free. A fill-or-kill add first walks the opposite chain one cell a cycle to
// total the crossing depth, and a rejected one then goes straight to its
// status item. A cancel passes through the rest, status and out states.
// Inserts and removals shift the whole chain together. A trade or the status
// item that waits on the output stalls the unit. Each input ends with one
// status item (last = 1). One item is in work at a time.
module limit_order_book_matcher_unit #(
  parameter int unsigned BOOK_SLOTS = lobm_pkg::BOOK_SLOTS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        func,
  input  logic [31:0] order_id,
  input  logic        side,
  input  logic [1:0]  order_type,
  input  logic [31:0] price,
  input  logic [31:0] quantity,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  kind,
  output logic [31:0] buyer_id,
  output logic [31:0] seller_id,
  output logic [31:0] trade_price,
  output logic [31:0] trade_qty,
  output logic [31:0] best_bid_price,
  output logic        bid_present,
  output logic [31:0] best_ask_price,
  output logic        ask_present,
  output logic        last
);
  import lobm_pkg::*;
  localparam int unsigned IW = $clog2(BOOK_SLOTS+1);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_SCAN  = 3'd1;
  localparam logic [2:0] ST_MATCH = 3'd2;
  localparam logic [2:0] ST_REST  = 3'd3;
  localparam logic [2:0] ST_STAT  = 3'd4;
  localparam logic [2:0] ST_OUT   = 3'd5;

  logic [2:0]  state;
  logic        r_func, r_side;
  logic [1:0]  r_type;
  logic [31:0] r_id, r_price, r_qty, depth;
  logic [IW-1:0] idx;
  logic [2:0]  r_kind;

  book_cmd_t bcmd, acmd;
  entry_t bhead, ahead, bscan, ascan, ohead, oscan;
  logic bfull, afull, bhit, ahit;

  lobm_book #(.BOOK_SLOTS(BOOK_SLOTS)) u_bid (
    .clk(clk), .rst(rst), .cmd(bcmd), .scan_idx(idx),
    .head(bhead), .scan_entry(bscan), .full(bfull), .any_hit(bhit));
  lobm_book #(.BOOK_SLOTS(BOOK_SLOTS)) u_ask (
    .clk(clk), .rst(rst), .cmd(acmd), .scan_idx(idx),
    .head(ahead), .scan_entry(ascan), .full(afull), .any_hit(ahit));

  logic out_free, crosses, scan_cross;
  logic [31:0] fill;
  logic [32:0] dsum;

  assign out_free = !out_valid || out_ready;
  assign in_ready = (state == ST_IDLE);
  assign ohead = r_side ? bhead : ahead;
  assign oscan = r_side ? bscan : ascan;
  assign crosses = r_side ? (ohead.price >= r_price) : (ohead.price <= r_price);
  assign scan_cross = oscan.valid &&
    (r_side ? (oscan.price >= r_price) : (oscan.price <= r_price));
  assign fill = (r_qty < ohead.qty) ? r_qty : ohead.qty;
  assign dsum = {1'b0, depth} + {1'b0, oscan.qty};

  logic can_match;
  assign can_match = (r_qty != 32'd0) && ohead.valid &&
                     ((r_type == TYPE_MARKET) || crosses);

  logic out_load;
  assign out_load = out_free &&
                    (((state == ST_MATCH) && can_match) || (state == ST_STAT));

  always_comb begin
    bcmd = '0;
    acmd = '0;
    bcmd.is_bid = 1'b1;
    bcmd.key = r_id;
    acmd.key = r_id;
    bcmd.new_entry = '{id: r_id, price: r_price, qty: r_qty, valid: 1'b1};
    acmd.new_entry = bcmd.new_entry;
    bcmd.amount = fill;
    acmd.amount = fill;
    unique case (state)
      ST_MATCH: begin
        if (can_match && out_free) begin
          if (r_side) bcmd.dec = 1'b1;
          else acmd.dec = 1'b1;
        end
      end
      ST_REST: begin
        if (r_func == FUNC_CANCEL) begin
          if (bhit) bcmd.rm = 1'b1;
          else acmd.rm = 1'b1;
        end else if (r_kind == KIND_RESTED) begin
          if (r_side) acmd.ins = 1'b1;
          else bcmd.ins = 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      if (out_load) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
      unique case (state)
        ST_IDLE: begin
          if (in_valid) begin
            r_func <= func; r_id <= order_id; r_side <= side;
            r_type <= order_type; r_price <= price; r_qty <= quantity;
            depth <= '0;
            idx <= '0;
            if (func == FUNC_CANCEL) state <= ST_REST;
            else if (order_type == TYPE_FOK) state <= ST_SCAN;
            else state <= ST_MATCH;
          end
        end
        ST_SCAN: begin
          if (scan_cross && idx < IW'(BOOK_SLOTS)) begin
            depth <= dsum[32] ? 32'hFFFF_FFFF : dsum[31:0];
            idx <= idx + IW'(1);
          end else if (depth < r_qty) begin
            r_kind <= KIND_FOK_REJ;
            state <= ST_STAT;
          end else begin
            state <= ST_MATCH;
          end
        end
        ST_MATCH: begin
          if (!can_match) begin
            if (r_qty != 32'd0 && (r_type == TYPE_LIMIT || r_type == TYPE_LIMIT3))
              r_kind <= (r_side ? afull : bfull) ? KIND_FULL : KIND_RESTED;
            else
              r_kind <= KIND_DONE;
            state <= ST_REST;
          end else if (out_free) begin
            kind <= KIND_TRADE;
            buyer_id <= r_side ? ohead.id : r_id;
            seller_id <= r_side ? r_id : ohead.id;
            trade_price <= ohead.price;
            trade_qty <= fill;
            best_bid_price <= '0; bid_present <= 1'b0;
            best_ask_price <= '0; ask_present <= 1'b0;
            last <= 1'b0;
            r_qty <= r_qty - fill;
          end
        end
        ST_REST: begin
          if (r_func == FUNC_CANCEL)
            r_kind <= (bhit || ahit) ? KIND_CANCELLED : KIND_NOT_FOUND;
          state <= ST_STAT;
        end
        ST_STAT: begin
          if (out_free) begin
            kind <= r_kind;
            buyer_id <= '0; seller_id <= '0;
            trade_price <= '0; trade_qty <= '0;
            best_bid_price <= bhead.valid ? bhead.price : 32'd0;
            bid_present <= bhead.valid;
            best_ask_price <= ahead.valid ? ahead.price : 32'd0;
            ask_present <= ahead.valid;
            last <= 1'b1;
            state <= ST_OUT;
          end
        end
        ST_OUT: state <= ST_IDLE;
        default: state <= ST_IDLE;
      endcase
    end
  end
endmodule

### sv/lobm_cell.sv
`timescale 1ns / 1ps
module lobm_cell (
  input  logic               clk,
  input  logic               rst,
  input  lobm_pkg::book_cmd_t cmd,
  input  lobm_pkg::entry_t   prev_entry,  // neighbor toward the head
  input  logic               prev_ins_here, // an earlier cell took the new entry
  input  lobm_pkg::entry_t   next_entry,  // neighbor toward the tail
  input  logic               prev_removed,  // an earlier cell was removed
  input  logic               is_head,
  output lobm_pkg::entry_t   entry,
  output logic               ins_here_out,
  output logic               removed_out,
  output logic               id_hit
);
  import lobm_pkg::*;

  entry_t entry_next;
  logic   better;
  logic   my_pos;
  logic   kill;

  always_comb begin
    better = cmd.is_bid ? (cmd.new_entry.price > entry.price)
                        : (cmd.new_entry.price < entry.price);
    my_pos = !entry.valid || better;
    ins_here_out = prev_ins_here || my_pos;
    id_hit = entry.valid && (entry.id == cmd.key);
    // A cancel removes only the first matching cell; a drain removes the head.
    kill = is_head ? (cmd.dec ? (entry.qty == cmd.amount) : id_hit)
                   : (id_hit && !prev_removed && !cmd.dec);
    removed_out = prev_removed || (kill && entry.valid);
    entry_next = entry;
    if (cmd.ins) begin
      if (prev_ins_here) entry_next = prev_entry;
      else if (my_pos) entry_next = cmd.new_entry;
    end else if (cmd.rm) begin
      if (removed_out) begin
        entry_next = next_entry;
      end
    end else if (cmd.dec) begin
      // An emptied head pulls the whole chain up by one cell.
      if (removed_out) entry_next = next_entry;
      else if (is_head) entry_next.qty = entry.qty - cmd.amount;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      entry.valid <= 1'b0;
    end else begin
      entry <= entry_next;
    end
  end
endmodule

### sv/lobm_book.sv
`timescale 1ns / 1ps
module lobm_book #(
  parameter int unsigned BOOK_SLOTS = lobm_pkg::BOOK_SLOTS_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  lobm_pkg::book_cmd_t cmd,
  input  logic [$clog2(BOOK_SLOTS+1)-1:0] scan_idx,
  output lobm_pkg::entry_t    head,
  output lobm_pkg::entry_t    scan_entry,
  output logic                full,
  output logic                any_hit
);
  import lobm_pkg::*;

  entry_t ent [BOOK_SLOTS+1];
  logic   ins_c [BOOK_SLOTS+1];
  logic   rem_c [BOOK_SLOTS+1];
  logic [BOOK_SLOTS-1:0] hits;

  assign ent[BOOK_SLOTS] = '0;
  assign ins_c[0] = 1'b0;
  assign rem_c[0] = 1'b0;

  for (genvar g = 0; g < BOOK_SLOTS; g++) begin : g_cell
    entry_t prev_e;
    if (g == 0) begin : g_h
      assign prev_e = '0;
    end else begin : g_b
      assign prev_e = ent[g-1];
    end
    lobm_cell u_cell (
      .clk(clk), .rst(rst), .cmd(cmd),
      .prev_entry(prev_e), .prev_ins_here(ins_c[g]),
      .next_entry(ent[g+1]), .prev_removed(rem_c[g]),
      .is_head(g == 0), .entry(ent[g]),
      .ins_here_out(ins_c[g+1]), .removed_out(rem_c[g+1]), .id_hit(hits[g])
    );
  end

  assign head = ent[0];
  assign full = ent[BOOK_SLOTS-1].valid;
  assign any_hit = |hits;
  // The extra entry past the tail is always empty, so it ends a scan.
  always_comb begin
    scan_entry = '0;
    if (scan_idx <= ($clog2(BOOK_SLOTS+1))'(BOOK_SLOTS))
      scan_entry = ent[scan_idx];
  end
endmodule
